FILE: hw/rtl/ga_pkg.sv
// Shared constants, selector codes and table-building functions for the GELU block.
`timescale 1ns / 1ps
`default_nettype none

package ga_pkg;

	// Default configuration of the block.
	localparam int DATA_WIDTH_DEF    = 16;
	localparam int FRAC_BITS_DEF     = 12;
	localparam int TABLE_ENTRIES_DEF = 256;

	// Phi is unsigned Q0.16.
	localparam int PHI_W = 16;

	// Register stages from the input register to the output register.
	localparam int PIPE_STAGES = 6;

	// Fixed-point constants used while building the Phi table.
	localparam logic [63:0] ONE56            = 64'd1 << 56;
	localparam logic [63:0] HALF30           = 64'd1 << 29;
	localparam logic [63:0] INV_SQRT_2PI_NUM = 64'd3989422804;
	localparam logic [63:0] INV_SQRT_2PI_DEN = 64'd10000000000;

	// Where Phi comes from for one request.
	typedef enum logic [1:0] {
		PHI_SEL_TABLE,
		PHI_SEL_LOW,
		PHI_SEL_HIGH
	} phi_sel_t;

	// floor(a * b / 2^56), keeping the low 64 bits of the quotient.
	function automatic logic [63:0] mul56(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[119:56];
	endfunction

	// Unsigned restoring division, one quotient bit per step.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Phi(t) - 1/2 in Q30 for t = a / te, with 0 <= t < 6.
	function automatic logic [63:0] half_phi(input int te, input logic [63:0] a);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] v;
		logic [63:0] e;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] h;
		t    = udiv64(a << 40, 64'(te)) << 16;
		t2   = mul56(t, t);
		v    = (t2 >> 1) >> 6;
		e    = ONE56;
		term = ONE56;
		// exp(-t^2/128) by its series, then raised to the 64th power.
		for (int k = 1; k <= 16; k++) begin
			term = udiv64(mul56(term, v), 64'(k));
			if (k % 2 == 1) begin
				e = e - term;
			end else begin
				e = e + term;
			end
		end
		for (int k = 0; k < 6; k++) begin
			e = mul56(e, e);
		end
		// Series for the integral of the normal density.
		term = mul56(t, e);
		s    = term;
		for (int n = 1; n <= 200; n++) begin
			if (term != 64'd0) begin
				term = udiv64(mul56(term, t2), 64'(2 * n + 1));
				s    = s + term;
			end
		end
		h = (s >> 26) * INV_SQRT_2PI_NUM / INV_SQRT_2PI_DEN;
		return (h > HALF30) ? HALF30 : h;
	endfunction

	// Table entry i of te: round(Phi(-8 + 16*i/te) * 65536), capped at the top code.
	function automatic logic [PHI_W-1:0] phi_entry(input int te, input int i);
		longint      m;
		logic [63:0] a;
		logic [63:0] h;
		logic [63:0] p;
		logic [63:0] q;
		m = 64'(16) * longint'(i) - 64'(8) * longint'(te);
		a = (m < 0) ? 64'(-m) : 64'(m);
		if (a >= 64'(6) * 64'(te)) begin
			h = HALF30;
		end else begin
			h = half_phi(te, a);
		end
		p = (m < 0) ? HALF30 - h : HALF30 + h;
		q = (p + 64'd8192) >> 14;
		return (q > 64'd65535) ? 16'hFFFF : q[PHI_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ga_in_if.sv
// Input stream interface: valid/ready handshake carrying one signed sample.
`timescale 1ns / 1ps
`default_nettype none

interface ga_in_if #(
	parameter int DATA_WIDTH = ga_pkg::DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ga_out_if.sv
// Output stream interface: valid/ready handshake carrying one signed result.
`timescale 1ns / 1ps
`default_nettype none

interface ga_out_if #(
	parameter int DATA_WIDTH = ga_pkg::DATA_WIDTH_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] y_value;

	modport source (output valid, output y_value, input ready);
	modport sink (input valid, input y_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ga_index.sv
// Stage 1: range check of the sample and split of its table position into index and fraction.
`timescale 1ns / 1ps
`default_nettype none

module ga_index #(
	parameter int DATA_WIDTH    = ga_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS     = ga_pkg::FRAC_BITS_DEF,
	parameter int TABLE_ENTRIES = ga_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	ga_in_if.sink                                  sample,
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output logic signed [DATA_WIDTH-1:0]           x_s1,
	output ga_pkg::phi_sel_t                       sel_s1,
	output logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx_s1,
	output logic [FRAC_BITS+3:0]                   r_s1
);
	import ga_pkg::*;

	localparam int SPAN_W = FRAC_BITS + 4;
	localparam int TE_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int P_W    = SPAN_W + TE_W;
	localparam int XW     = ((DATA_WIDTH > FRAC_BITS + 5) ? DATA_WIDTH : FRAC_BITS + 5) + 1;
	localparam logic signed [XW-1:0] EIGHT = XW'(64'd8 << FRAC_BITS);

	logic                     v_s1;
	logic                     en_s1;
	logic signed [XW-1:0]     xe;
	logic signed [XW-1:0]     u;
	logic                     below;
	logic                     above;
	logic [P_W-1:0]           p;
	phi_sel_t                 sel;

	// The stage takes a request whenever it is empty or its content moves on.
	assign en_s1        = !v_s1 || dn_ready;
	assign sample.ready = en_s1;
	assign dn_valid     = v_s1;

	// Offset the sample by eight so the table span starts at zero.
	assign xe    = XW'(sample.x_value);
	assign u     = xe + EIGHT;
	assign below = u[XW-1];
	assign above = !u[XW-1] && (|u[XW-2:SPAN_W]);
	assign p     = P_W'(u[SPAN_W-1:0]) * P_W'(TABLE_ENTRIES);

	always_comb begin
		if (below) begin
			sel = PHI_SEL_LOW;
		end else if (above) begin
			sel = PHI_SEL_HIGH;
		end else begin
			sel = PHI_SEL_TABLE;
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample.valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1   <= sample.x_value;
			sel_s1 <= sel;
			idx_s1 <= p[P_W-1:SPAN_W];
			r_s1   <= p[SPAN_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ga_interp.sv
// Stages 2 to 4: Phi table read, slope times fraction, and rounded interpolation.
`timescale 1ns / 1ps
`default_nettype none

module ga_interp #(
	parameter int DATA_WIDTH    = ga_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS     = ga_pkg::FRAC_BITS_DEF,
	parameter int TABLE_ENTRIES = ga_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  logic signed [DATA_WIDTH-1:0]           x,
	input  ga_pkg::phi_sel_t                       sel,
	input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     idx,
	input  logic [FRAC_BITS+3:0]                   r,
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output logic signed [DATA_WIDTH-1:0]           x_s4,
	output logic [ga_pkg::PHI_W-1:0]               phi_s4
);
	import ga_pkg::*;

	localparam int SPAN_W = FRAC_BITS + 4;
	localparam int TE_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int DR_W   = PHI_W + SPAN_W;
	localparam logic [DR_W-1:0] HALF_SPAN = {{(DR_W-1){1'b0}}, 1'b1} << (SPAN_W - 1);
	localparam logic [PHI_W-1:0] PHI_LO = phi_entry(TABLE_ENTRIES, 0);
	localparam logic [PHI_W-1:0] PHI_HI = phi_entry(TABLE_ENTRIES, TABLE_ENTRIES);

	logic [PHI_W-1:0] phi_tab [TABLE_ENTRIES+1];

	logic                         v_s2, v_s3, v_s4;
	logic                         en_s2, en_s3, en_s4;
	logic [TE_W-1:0]              idx_next;
	logic [PHI_W-1:0]             tab_a, tab_b;
	logic [PHI_W-1:0]             a_s2, a_s3;
	logic [PHI_W-1:0]             d_s2;
	logic [SPAN_W-1:0]            r_s2;
	logic signed [DATA_WIDTH-1:0] x_s2, x_s3;
	phi_sel_t                     sel_s2, sel_s3;
	logic [DR_W-1:0]              dr_s3;
	logic [DR_W-1:0]              dr_round;
	logic [PHI_W:0]               phi_sum;
	logic [PHI_W-1:0]             phi;

	// Phi samples at the table points, fixed at elaboration.
	for (genvar i = 0; i <= TABLE_ENTRIES; i++) begin : g_tab
		localparam logic [PHI_W-1:0] ENTRY = phi_entry(TABLE_ENTRIES, i);
		assign phi_tab[i] = ENTRY;
	end

	// Each stage moves when it is empty or the one after it moves.
	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign up_ready = en_s2;
	assign dn_valid = v_s4;

	// Two neighboring table points; a falling step counts as flat.
	assign idx_next = idx + TE_W'(1);
	assign tab_a    = phi_tab[idx];
	assign tab_b    = phi_tab[idx_next];

	// Rounded interpolation, or a table end for samples outside the span.
	assign dr_round = dr_s3 + HALF_SPAN;
	assign phi_sum  = {1'b0, a_s3} + {1'b0, dr_round[DR_W-1:SPAN_W]};

	always_comb begin
		case (sel_s3)
			PHI_SEL_LOW:  phi = PHI_LO;
			PHI_SEL_HIGH: phi = PHI_HI;
			default:      phi = phi_sum[PHI_W-1:0];
		endcase
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= up_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Payload of the three stages.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			x_s2   <= x;
			sel_s2 <= sel;
			r_s2   <= r;
			a_s2   <= tab_a;
			d_s2   <= (tab_b >= tab_a) ? tab_b - tab_a : '0;
		end
		if (en_s3) begin
			x_s3   <= x_s2;
			sel_s3 <= sel_s2;
			a_s3   <= a_s2;
			dr_s3  <= DR_W'(d_s2) * DR_W'(r_s2);
		end
		if (en_s4) begin
			x_s4   <= x_s3;
			phi_s4 <= phi;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ga_product.sv
// Stages 5 and 6: sample times Phi, rounding to the sample format, and saturation.
`timescale 1ns / 1ps
`default_nettype none

module ga_product #(
	parameter int DATA_WIDTH = ga_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic signed [DATA_WIDTH-1:0] x,
	input  logic [ga_pkg::PHI_W-1:0]     phi,
	ga_out_if.source                     result
);
	import ga_pkg::*;

	localparam int MUL_W = DATA_WIDTH + PHI_W + 1;
	localparam int SUM_W = MUL_W + 1;
	localparam int Y_W   = SUM_W - PHI_W;
	localparam logic [SUM_W-1:0] ROUND = {{(SUM_W-1){1'b0}}, 1'b1} << (PHI_W - 1);
	localparam logic signed [Y_W-1:0] Y_MAX = {{(Y_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [Y_W-1:0] Y_MIN = {{(Y_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

	logic                         v_s5, v_s6;
	logic                         en_s5, en_s6;
	logic signed [MUL_W-1:0]      prod;
	logic signed [MUL_W-1:0]      prod_s5;
	logic signed [SUM_W-1:0]      sum;
	logic signed [Y_W-1:0]        y_full;
	logic signed [DATA_WIDTH-1:0] y_sat;
	logic signed [DATA_WIDTH-1:0] y_s6;

	// The output register parts the pipeline from the receiver.
	assign en_s6          = !v_s6 || result.ready;
	assign en_s5          = !v_s5 || en_s6;
	assign up_ready       = en_s5;
	assign result.valid   = v_s6;
	assign result.y_value = y_s6;

	// Phi is unsigned, so it enters the product with a zero sign bit.
	assign prod = MUL_W'(x) * MUL_W'($signed({1'b0, phi}));

	// Round half up, drop the Q0.16 fraction, then clamp to the sample range.
	assign sum    = SUM_W'(prod_s5) + $signed(ROUND);
	assign y_full = sum[SUM_W-1:PHI_W];

	always_comb begin
		if (y_full > Y_MAX) begin
			y_sat = Y_MAX[DATA_WIDTH-1:0];
		end else if (y_full < Y_MIN) begin
			y_sat = Y_MIN[DATA_WIDTH-1:0];
		end else begin
			y_sat = y_full[DATA_WIDTH-1:0];
		end
	end

	// Valid bits of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) begin
				v_s5 <= up_valid;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Payload of the two stages.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			prod_s5 <= prod;
		end
		if (en_s6) begin
			y_s6 <= y_sat;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gelu_activation.sv
// GELU activation x * Phi(x) on a stream of signed fixed-point samples, exact erf form.
//
// Channels: sample carries one signed x_value (Q4.12 by default) per request, result
// carries one y_value of the same format per request, both with valid/ready handshakes.
// Every request yields exactly one result, in order.
// Throughput is one request per cycle while the receiver is ready. An accepted sample
// passes through the six-stage pipeline: index split, Phi table read, slope multiply,
// interpolation, product, and rounding with saturation into the output register.
// Phi comes from a constant table over [-8, 8] with linear interpolation; samples
// outside that span take the end values of the table.
// Reset clears the valid bit of every stage; the block can take a request as soon as
// reset is released and needs no clearing pass.
// When the receiver stalls, the output register holds its result and the stages
// behind it keep filling until every stage is occupied; only then does sample.ready
// fall. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module gelu_activation #(
	parameter int DATA_WIDTH    = ga_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS     = ga_pkg::FRAC_BITS_DEF,
	parameter int TABLE_ENTRIES = ga_pkg::TABLE_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	ga_in_if.sink    sample,
	ga_out_if.source result
);
	import ga_pkg::*;

	localparam int TE_W   = $clog2(TABLE_ENTRIES + 1);
	localparam int SPAN_W = FRAC_BITS + 4;

	logic                         v_s1;
	logic                         rdy_s2;
	logic signed [DATA_WIDTH-1:0] x_s1;
	phi_sel_t                     sel_s1;
	logic [TE_W-1:0]              idx_s1;
	logic [SPAN_W-1:0]            r_s1;
	logic                         v_s4;
	logic                         rdy_s5;
	logic signed [DATA_WIDTH-1:0] x_s4;
	logic [PHI_W-1:0]             phi_s4;

	// Range check and table position.
	ga_index #(
		.DATA_WIDTH    (DATA_WIDTH),
		.FRAC_BITS     (FRAC_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.dn_valid (v_s1),
		.dn_ready (rdy_s2),
		.x_s1     (x_s1),
		.sel_s1   (sel_s1),
		.idx_s1   (idx_s1),
		.r_s1     (r_s1)
	);

	// Table read and interpolation of Phi.
	ga_interp #(
		.DATA_WIDTH    (DATA_WIDTH),
		.FRAC_BITS     (FRAC_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s1),
		.up_ready (rdy_s2),
		.x        (x_s1),
		.sel      (sel_s1),
		.idx      (idx_s1),
		.r        (r_s1),
		.dn_valid (v_s4),
		.dn_ready (rdy_s5),
		.x_s4     (x_s4),
		.phi_s4   (phi_s4)
	);

	// Product, rounding and saturation.
	ga_product #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s4),
		.up_ready (rdy_s5),
		.x        (x_s4),
		.phi      (phi_s4),
		.result   (result)
	);

`ifndef ASSERT_OFF
	localparam int OCC_W = $clog2(PIPE_STAGES + 1);
	logic [OCC_W-1:0] occ_q;

	// Requests inside the pipeline, counted at the ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(sample.valid && sample.ready)
				- OCC_W'(result.valid && result.ready);
		end
	end

	// The pipeline never holds more requests than it has stages.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_STAGES))
		else $error("pipeline holds more requests than stages");

	// Input back-pressure only when every stage is full and the receiver stalls.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (occ_q == OCC_W'(PIPE_STAGES)) && result.valid && !result.ready)
		else $error("sample refused while the pipeline has room");

	// A result is only shown for a request that was taken.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> occ_q != '0)
		else $error("result shown with no request in flight");
`endif

endmodule

`default_nettype wire
